// ----- src/b64e_pkg.sv -----
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
`timescale 1ns / 1ps

package b64e_pkg;

  // Characters one byte can produce at most
  localparam int unsigned MaxChars   = 4;
  localparam int unsigned CharIdxW   = $clog2(MaxChars);
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] PadChar = 8'h3D;  // '='

  // Pending bit-pair counts
  localparam logic [1:0] PairsNone = 2'd0;
  localparam logic [1:0] PairsOne  = 2'd1;
  localparam logic [1:0] PairsTwo  = 2'd2;

  // One queued job: the characters a byte yields, index of the last one,
  // and whether that last one closes the message
  typedef struct packed {
    logic [MaxChars-1:0][7:0] chars;
    logic [CharIdxW-1:0]      last_idx;
    logic                     msg_end;
  } job_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
  function automatic logic [7:0] b64_char(input logic [5:0] grp);
    logic [7:0] g;
    logic [7:0] ch;
    g = {2'b00, grp};
    if (g < 8'd26) begin
      ch = 8'h41 + g;
    end else if (g < 8'd52) begin
      ch = 8'h61 + (g - 8'd26);
    end else if (g < 8'd62) begin
      ch = 8'h30 + (g - 8'd52);
    end else if (g == 8'd62) begin
      ch = 8'h2B;
    end else begin
      ch = 8'h2F;
    end
    return ch;
  endfunction

endpackage

// ----- src/b64e_if.sv -----
// Valid/ready channel interfaces for raw bytes in and characters out.
`timescale 1ns / 1ps

interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       final_char;

  modport source (output valid, output out_char, output final_char, input ready);
  modport sink   (input valid, input out_char, input final_char, output ready);
endinterface

// ----- src/base64_stream_encoder.sv -----
// An accepted byte's job is written into the queue; its characters then leave through
// the single-character output register, one character per cycle while the receiver is
// ready. A byte yields 1 to 2 characters (up to 4 for a message's last byte).
// Bytes are taken every cycle while the job queue has room.
// Reset (rst_ni low, asynchronous) clears pending bits, the queue and the output.
`timescale 1ns / 1ps

module base64_stream_encoder #(
  parameter int unsigned QueueDepth = b64e_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  b64e_byte_if.sink   in_ch_i,
  b64e_char_if.source out_ch_o
);

  b64e_pkg::job_t push_job;
  b64e_pkg::job_t head_job;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  b64e_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_ch_i.valid),
    .in_ready_o       (in_ch_i.ready),
    .data_byte_i      (in_ch_i.data_byte),
    .end_of_message_i (in_ch_i.end_of_message),
    .q_full_i         (q_full),
    .push_o           (push),
    .job_o            (push_job)
  );

  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .full_o     (q_full),
    .empty_o    (q_empty),
    .head_o     (head_job)
  );

  b64e_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_ch_o.valid),
    .out_ready_i  (out_ch_o.ready),
    .out_char_o   (out_ch_o.out_char),
    .final_char_o (out_ch_o.final_char)
  );

endmodule

// ----- src/b64e_front.sv -----
// Front end: takes bytes, tracks leftover bits and builds per-byte character jobs.
`timescale 1ns / 1ps

module b64e_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_message_i,
  input  logic              q_full_i,
  output logic              push_o,
  output b64e_pkg::job_t    job_o
);

  logic [3:0] pend_q, pend_d;
  logic [1:0] pairs_q, pairs_d;
  logic       accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;

  // Split the byte against the pending bits
  always_comb begin
    job_o          = '0;
    job_o.msg_end  = end_of_message_i;
    pend_d         = pend_q;
    pairs_d        = pairs_q;
    unique case (pairs_q)
      b64e_pkg::PairsOne: begin
        job_o.chars[0] = b64e_pkg::b64_char({pend_q[1:0], data_byte_i[7:4]});
        if (end_of_message_i) begin
          job_o.chars[1] = b64e_pkg::b64_char({data_byte_i[3:0], 2'b00});
          job_o.chars[2] = b64e_pkg::PadChar;
          job_o.last_idx = 2'd2;
        end else begin
          job_o.last_idx = 2'd0;
        end
        pend_d  = data_byte_i[3:0];
        pairs_d = b64e_pkg::PairsTwo;
      end
      b64e_pkg::PairsTwo: begin
        job_o.chars[0] = b64e_pkg::b64_char({pend_q, data_byte_i[7:6]});
        job_o.chars[1] = b64e_pkg::b64_char(data_byte_i[5:0]);
        job_o.last_idx = 2'd1;
        pend_d         = 4'd0;
        pairs_d        = b64e_pkg::PairsNone;
      end
      default: begin
        // no bits pending (an impossible count of three lands here too)
        job_o.chars[0] = b64e_pkg::b64_char(data_byte_i[7:2]);
        if (end_of_message_i) begin
          job_o.chars[1] = b64e_pkg::b64_char({data_byte_i[1:0], 4'b0000});
          job_o.chars[2] = b64e_pkg::PadChar;
          job_o.chars[3] = b64e_pkg::PadChar;
          job_o.last_idx = 2'd3;
        end else begin
          job_o.last_idx = 2'd0;
        end
        pend_d  = {2'b00, data_byte_i[1:0]};
        pairs_d = b64e_pkg::PairsOne;
      end
    endcase
    // message end returns to the reset state
    if (end_of_message_i) begin
      pend_d  = 4'd0;
      pairs_d = b64e_pkg::PairsNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 4'd0;
      pairs_q <= b64e_pkg::PairsNone;
    end else if (accept) begin
      pend_q  <= pend_d;
      pairs_q <= pairs_d;
    end
  end

endmodule

// ----- src/b64e_queue.sv -----
// Small job queue between the front end and the character emitter.
`timescale 1ns / 1ps

module b64e_queue #(
  parameter int unsigned Depth = b64e_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64e_pkg::job_t push_job_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output b64e_pkg::job_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64e_pkg::job_t    slots_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = slots_q[rd_ptr_q];

  // Job storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- src/b64e_back.sv -----
// Back end: walks the head job one character per cycle into the output register while it is free or being drained.
`timescale 1ns / 1ps

module b64e_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  b64e_pkg::job_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_char_o,
  output logic           final_char_o
);

  logic [b64e_pkg::CharIdxW-1:0] idx_q;
  logic                          valid_q;
  logic [7:0]                    char_q;
  logic                          final_q;
  logic                          load;
  logic                          at_last;

  // Output register takes a new beat when a job is queued and the register is empty or being drained
  assign load    = !q_empty_i && (!valid_q || out_ready_i);
  assign at_last = (idx_q == head_i.last_idx);
  assign pop_o   = load && at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= at_last ? '0 : idx_q + 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q  <= head_i.chars[idx_q];
      final_q <= head_i.msg_end && at_last;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_char_o   = char_q;
  assign final_char_o = final_q;

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the base64 stream encoder: byte beats in, character beats out.
`timescale 1ns / 1ps

module testbench;

  // Predicts the characters each accepted byte yields and checks them in order
  class b64_scoreboard;
    typedef struct packed {
      logic [7:0] ch;
      logic       fin;
    } char_beat_t;

    char_beat_t  expected_chars[$];
    logic [3:0]  carry_bits;
    logic [1:0]  carry_pairs;
    int unsigned mismatches;
    string       alphabet;

    function new();
      alphabet    = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      carry_bits  = 4'd0;
      carry_pairs = b64e_pkg::PairsNone;
      mismatches  = 0;
    endfunction

    function logic [7:0] glyph(input logic [5:0] grp);
      return alphabet[grp];
    endfunction

    // Work out the characters for one accepted byte beat
    function void note_byte(input logic [7:0] b, input logic eom);
      logic [7:0] chars [4];
      int         n;
      logic [1:0] pairs;
      char_beat_t beat;
      pairs = (carry_pairs == 2'd3) ? b64e_pkg::PairsNone : carry_pairs;
      n     = 0;
      case (pairs)
        b64e_pkg::PairsNone: begin
          chars[0] = glyph(b[7:2]);
          if (eom) begin
            chars[1] = glyph({b[1:0], 4'b0000});
            chars[2] = b64e_pkg::PadChar;
            chars[3] = b64e_pkg::PadChar;
            n        = 4;
          end else begin
            n           = 1;
            carry_bits  = {2'b00, b[1:0]};
            carry_pairs = b64e_pkg::PairsOne;
          end
        end
        b64e_pkg::PairsOne: begin
          // only the low pair of the carried bits is live here
          chars[0] = glyph({carry_bits[1:0], b[7:4]});
          if (eom) begin
            chars[1] = glyph({b[3:0], 2'b00});
            chars[2] = b64e_pkg::PadChar;
            n        = 3;
          end else begin
            n           = 1;
            carry_bits  = b[3:0];
            carry_pairs = b64e_pkg::PairsTwo;
          end
        end
        default: begin
          chars[0]    = glyph({carry_bits, b[7:6]});
          chars[1]    = glyph(b[5:0]);
          n           = 2;
          carry_bits  = 4'd0;
          carry_pairs = b64e_pkg::PairsNone;
        end
      endcase
      if (eom) begin
        carry_bits  = 4'd0;
        carry_pairs = b64e_pkg::PairsNone;
      end
      for (int i = 0; i < n; i++) begin
        beat.ch  = chars[i];
        beat.fin = eom && (i == n - 1);
        expected_chars.insert(expected_chars.size(), beat);
      end
    endfunction

    // Compare one accepted character beat with the oldest prediction
    function void check_char(input logic [7:0] ch, input logic fin);
      char_beat_t exp_beat;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected char 0x%02h final %0b", $realtime, ch, fin);
        return;
      end
      exp_beat = expected_chars.pop_front();
      if (ch !== exp_beat.ch || fin !== exp_beat.fin) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: char mismatch: expected 0x%02h final %0b, got 0x%02h final %0b",
                   $realtime, exp_beat.ch, exp_beat.fin, ch, fin);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   steady;  // no idling on either side while set

  b64e_byte_if byte_ch ();
  b64e_char_if char_ch ();

  b64_scoreboard sb = new();

  base64_stream_encoder DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (byte_ch),
    .out_ch_o (char_ch)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    char_ch.ready <= steady || ($urandom_range(99) >= 18);
  end

  // Monitor both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (byte_ch.valid && byte_ch.ready)
        sb.note_byte(byte_ch.data_byte, byte_ch.end_of_message);
      if (char_ch.valid && char_ch.ready)
        sb.check_char(char_ch.out_char, char_ch.final_char);
    end
  end

  // One byte beat, with random idle cycles ahead of it unless steady is set
  task automatic send_byte(input logic [7:0] b, input logic eom);
    if (!steady) begin
      while ($urandom_range(99) < 18) begin
        byte_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    byte_ch.valid          <= 1'b1;
    byte_ch.data_byte      <= b;
    byte_ch.end_of_message <= eom;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
  endtask

  // Directed messages: all-zero and all-one bytes, each padding length,
  // and a known text; the last flag marks message ends
  logic [7:0] dir_bytes [24] = '{
    8'h00,
    8'hFF,
    8'h00, 8'hFF,
    8'hFF, 8'h00,
    8'hFF, 8'hFF, 8'hFF,
    8'h00, 8'h00, 8'h00,
    8'h4D, 8'h61, 8'h6E,
    8'hFB, 8'hEF, 8'hBE, 8'h7F,
    8'h0F, 8'hF0, 8'hAA, 8'h55, 8'hC3
  };
  logic dir_last [24] = '{
    1'b1,
    1'b1,
    1'b0, 1'b1,
    1'b0, 1'b1,
    1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b1
  };

  // Stimulus and end of run
  initial begin
    int unsigned sent;
    int unsigned msg_len;
    rst_ni                 = 1'b0;
    steady                 = 1'b0;
    byte_ch.valid          = 1'b0;
    byte_ch.data_byte      = 8'h00;
    byte_ch.end_of_message = 1'b0;
    char_ch.ready          = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 24; i++) send_byte(dir_bytes[i], dir_last[i]);

    // Random messages, mostly short, now and then long ones
    sent = 0;
    while (sent < 400) begin
      msg_len = ($urandom_range(9) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 1);
      for (int k = 0; k < msg_len; k++) begin
        steady = (sent >= 150 && sent < 280);
        send_byte(8'($urandom_range(255)), (k == msg_len - 1));
        sent++;
      end
    end
    steady = 1'b0;
    byte_ch.valid <= 1'b0;

    // Drain, then allow for any stray late characters
    while (sb.expected_chars.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.expected_chars.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/b64e_pkg.sv
src/b64e_if.sv
src/b64e_front.sv
src/b64e_queue.sv
src/b64e_back.sv
src/base64_stream_encoder.sv
tb/sv/testbench.sv
